>>> hdl/scd_pkg.sv
`timescale 1ns / 1ps
package scd_pkg;

    localparam int ENTRIES_DEF = 256;
    localparam int ADDR_W      = 48;
    localparam int SLOT_W      = 8;
    localparam int ACT_W       = 2;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic vict_rd;
        logic vict_wr;
        logic lw1;
        logic lw2;
        logic fscan;
        logic frd;
        logic publish;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic scan_hit;
        logic scan_miss;
        logic s_newest;
        logic fs_found;
        logic fs_end;
        logic out_free;
        logic [ACT_W-1:0] act;
    } sts_t;

endpackage

>>> hdl/scd_if.sv
`timescale 1ns / 1ps
interface scd_req_if;
    import scd_pkg::*;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] block_address;
    logic              mark_dirty;
    modport source (output valid, action, block_address, mark_dirty, input ready);
    modport sink (input valid, action, block_address, mark_dirty, output ready);
endinterface

interface scd_rsp_if;
    import scd_pkg::*;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              replaced;
    logic              writeback;
    logic [ADDR_W-1:0] writeback_address;
    modport source (output valid, hit, slot, replaced, writeback, writeback_address,
                    input ready);
    modport sink (input valid, hit, slot, replaced, writeback, writeback_address,
                  output ready);
endinterface

>>> hdl/scd_ram.sv
`timescale 1ns / 1ps
module scd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/scd_ctrl.sv
`timescale 1ns / 1ps
module scd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_action,
    output logic                in_ready,
    input  scd_pkg::sts_t       sts,
    output scd_pkg::cmd_t       cmd
);
    import scd_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_VICT  = 4'd3;
    localparam logic [3:0] S_VICT2 = 4'd4;
    localparam logic [3:0] S_LRD   = 4'd5;
    localparam logic [3:0] S_LW1   = 4'd6;
    localparam logic [3:0] S_LW2   = 4'd7;
    localparam logic [3:0] S_FSCAN = 4'd8;
    localparam logic [3:0] S_FRD   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_action)
                        ACT_LOOKUP, ACT_INSERT: state_next = S_SCAN;
                        ACT_FLUSH:              state_next = S_FSCAN;
                        default:                state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = S_LRD;
                end
                else if (sts.scan_miss)
                begin
                    state_next = (sts.act == ACT_INSERT) ? S_VICT : S_DONE;
                end
            end
            S_VICT:
            begin
                cmd.vict_rd = 1'b1;
                state_next = S_VICT2;
            end
            S_VICT2:
            begin
                cmd.vict_wr = 1'b1;
                state_next = S_LRD;
            end
            S_LRD:
            begin
                state_next = sts.s_newest ? S_DONE : S_LW1;
            end
            S_LW1:
            begin
                cmd.lw1 = 1'b1;
                state_next = S_LW2;
            end
            S_LW2:
            begin
                cmd.lw2 = 1'b1;
                state_next = S_DONE;
            end
            S_FSCAN:
            begin
                cmd.fscan = 1'b1;
                if (sts.fs_found)
                begin
                    state_next = S_FRD;
                end
                else if (sts.fs_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_FRD:
            begin
                cmd.frd = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> hdl/scd_datapath.sv
`timescale 1ns / 1ps
module scd_datapath #(
    parameter int ENTRIES = scd_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  scd_pkg::cmd_t               cmd,
    output scd_pkg::sts_t               sts,
    input  logic [1:0]                  in_action,
    input  logic [scd_pkg::ADDR_W-1:0]  in_address,
    input  logic                        in_mark,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        out_hit,
    output logic [scd_pkg::SLOT_W-1:0]  out_slot,
    output logic                        out_replaced,
    output logic                        out_writeback,
    output logic [scd_pkg::ADDR_W-1:0]  out_wb_address
);
    import scd_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]      s_reg, s_next;
    logic [IW-1:0]      newest_reg, newest_next;
    logic [IW-1:0]      oldest_reg, oldest_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] dirty_reg, dirty_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               mark_reg, mark_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic               hit_reg, hit_next;
    logic               repl_reg, repl_next;
    logic               wb_reg, wb_next;
    logic [ADDR_W-1:0]  wba_reg, wba_next;
    logic               ov_reg, ov_next;
    logic               oh_reg, oh_next;
    logic [SLOT_W-1:0]  os_reg, os_next;
    logic               or_reg, or_next;
    logic               ow_reg, ow_next;
    logic [ADDR_W-1:0]  oa_reg, oa_next;

    logic               tag_we;
    logic [IW-1:0]      tag_raddr;
    logic [ADDR_W-1:0]  tag_rdata;
    logic               old_we, new_we;
    logic [IW-1:0]      old_waddr, new_waddr;
    logic [IW-1:0]      old_wdata, new_wdata;
    logic [IW-1:0]      old_rdata, new_rdata;
    logic               scan_eq, scan_miss, fs_found;

    assign tag_raddr = cmd.vict_rd ? oldest_reg : idx_reg;

    scd_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_tag (
        .clk(clk), .we(tag_we), .waddr(oldest_reg), .wdata(addr_reg),
        .raddr(tag_raddr), .rdata(tag_rdata)
    );
    scd_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_older (
        .clk(clk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
        .raddr(s_reg), .rdata(old_rdata)
    );
    scd_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_newer (
        .clk(clk), .we(new_we), .waddr(new_waddr), .wdata(new_wdata),
        .raddr(s_reg), .rdata(new_rdata)
    );

    assign scan_eq   = cmp_vld_reg && valid_reg[cmp_idx_reg] && (tag_rdata == addr_reg);
    assign scan_miss = cmp_vld_reg && !scan_eq && (cmp_idx_reg == LAST);
    assign fs_found  = valid_reg[idx_reg] && dirty_reg[idx_reg];

    always_comb
    begin
        sts.clr_last  = (idx_reg == LAST);
        sts.scan_hit  = scan_eq;
        sts.scan_miss = scan_miss;
        sts.s_newest  = (s_reg == newest_reg);
        sts.fs_found  = fs_found;
        sts.fs_end    = !fs_found && (idx_reg == LAST);
        sts.out_free  = !ov_reg || out_ready;
        sts.act       = act_reg;
    end

    always_comb
    begin
        idx_next = idx_reg;       cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        s_next = s_reg;           newest_next = newest_reg;
        oldest_next = oldest_reg; valid_next = valid_reg;
        dirty_next = dirty_reg;   addr_next = addr_reg;
        mark_next = mark_reg;     act_next = act_reg;
        hit_next = hit_reg;       repl_next = repl_reg;
        wb_next = wb_reg;         wba_next = wba_reg;
        ov_next = ov_reg;         oh_next = oh_reg;
        os_next = os_reg;         or_next = or_reg;
        ow_next = ow_reg;         oa_next = oa_reg;
        tag_we = 1'b0;
        old_we = 1'b0; old_waddr = idx_reg; old_wdata = '0;
        new_we = 1'b0; new_waddr = idx_reg; new_wdata = '0;

        if (cmd.clr)
        begin
            // build the initial recency chain, one slot a cycle
            old_we = 1'b1;
            old_wdata = (idx_reg == '0) ? '0 : idx_reg - 1'b1;
            new_we = 1'b1;
            new_wdata = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
            idx_next = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
        end
        if (cmd.load)
        begin
            addr_next = in_address;  mark_next = in_mark;  act_next = in_action;
            idx_next = '0;  cmp_vld_next = 1'b0;  s_next = '0;
            hit_next = 1'b0;  repl_next = 1'b0;  wb_next = 1'b0;  wba_next = '0;
        end
        if (cmd.scan)
        begin
            idx_next = (idx_reg == LAST) ? idx_reg : idx_reg + 1'b1;
            cmp_idx_next = idx_reg;
            cmp_vld_next = 1'b1;
            if (scan_eq)
            begin
                hit_next = 1'b1;
                s_next = cmp_idx_reg;
                if (act_reg == ACT_INSERT)
                begin
                    dirty_next[cmp_idx_reg] = mark_reg;
                end
            end
        end
        if (cmd.vict_wr)
        begin
            s_next = oldest_reg;
            repl_next = valid_reg[oldest_reg];
            wb_next = valid_reg[oldest_reg] && dirty_reg[oldest_reg];
            wba_next = (valid_reg[oldest_reg] && dirty_reg[oldest_reg]) ? tag_rdata : '0;
            valid_next[oldest_reg] = 1'b1;
            dirty_next[oldest_reg] = mark_reg;
            tag_we = 1'b1;
        end
        if (cmd.lw1)
        begin
            // unlink the slot: older[n] = o, newer[o] = n
            old_we = 1'b1; old_waddr = new_rdata; old_wdata = old_rdata;
            if (s_reg == oldest_reg)
            begin
                oldest_next = new_rdata;
            end
            else
            begin
                new_we = 1'b1; new_waddr = old_rdata; new_wdata = new_rdata;
            end
        end
        if (cmd.lw2)
        begin
            old_we = 1'b1; old_waddr = s_reg; old_wdata = newest_reg;
            new_we = 1'b1; new_waddr = newest_reg; new_wdata = s_reg;
            newest_next = s_reg;
        end
        if (cmd.fscan)
        begin
            if (fs_found)
            begin
                s_next = idx_reg;
                dirty_next[idx_reg] = 1'b0;
                wb_next = 1'b1;
            end
            else if (idx_reg != LAST)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (cmd.frd)
        begin
            wba_next = tag_rdata;
        end
        if (cmd.publish)
        begin
            ov_next = 1'b1;
            oh_next = hit_reg;
            os_next = SLOT_W'(s_reg);
            or_next = repl_reg;
            ow_next = wb_reg;
            oa_next = wba_reg;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            newest_reg  <= LAST;
            oldest_reg  <= '0;
            valid_reg   <= '0;
            dirty_reg   <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            newest_reg  <= newest_next;
            oldest_reg  <= oldest_next;
            valid_reg   <= valid_next;
            dirty_reg   <= dirty_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        s_reg       <= s_next;
        addr_reg    <= addr_next;
        mark_reg    <= mark_next;
        act_reg     <= act_next;
        hit_reg     <= hit_next;
        repl_reg    <= repl_next;
        wb_reg      <= wb_next;
        wba_reg     <= wba_next;
        oh_reg      <= oh_next;
        os_reg      <= os_next;
        or_reg      <= or_next;
        ow_reg      <= ow_next;
        oa_reg      <= oa_next;
    end

    assign out_valid      = ov_reg;
    assign out_hit        = oh_reg;
    assign out_slot       = os_reg;
    assign out_replaced   = or_reg;
    assign out_writeback  = ow_reg;
    assign out_wb_address = oa_reg;
endmodule

>>> hdl/sector_cache_lru_directory.sv
`timescale 1ns / 1ps
// Tag directory of a fully associative sector cache with true LRU replacement.
// One request is handled at a time. Lookup and insert walk the tag memory one
// slot per cycle through its single read port; a hit or an insert then moves
// the slot to the head of the recency list in states S_LRD, S_LW1 and S_LW2,
// and an insert miss first reads and fills the victim in S_VICT and S_VICT2.
// A flush walks the valid and dirty bits one slot per cycle. After reset a
// clearing pass builds the initial recency chain in the link memories; no
// request is taken until it ends. The result sits in an output register, so
// the next request is taken while it waits to be read. The reported slot
// carries the low eight bits of the slot number.
module sector_cache_lru_directory #(
    parameter int ENTRIES = scd_pkg::ENTRIES_DEF
) (
    input logic      clk,
    input logic      rst_n,
    scd_req_if.sink  req,
    scd_rsp_if.source rsp
);
    import scd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequence each request
    scd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_action(req.action), .in_ready(req.ready),
        .sts(sts), .cmd(cmd)
    );

    // tags, state bits, recency links and the result register
    scd_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_action(req.action), .in_address(req.block_address),
        .in_mark(req.mark_dirty),
        .out_ready(rsp.ready), .out_valid(rsp.valid), .out_hit(rsp.hit),
        .out_slot(rsp.slot), .out_replaced(rsp.replaced),
        .out_writeback(rsp.writeback), .out_wb_address(rsp.writeback_address)
    );

`ifndef NO_ASSERTIONS
    // hold off the next request while one is in progress
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in progress");

    // a published result must show up at the output
    a_publish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> rsp.valid)
        else $error("result lost at publish");

    // relinking leaves the slot at the head of the list
    a_relink: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lw2 |=> sts.s_newest)
        else $error("slot not newest after relink");
`endif
endmodule
